// ===== sv/oesep_pkg.sv =====
// ============================================================================
// oesep_pkg - shared types and constants of the other-ensemble service parser
// Item and result layouts, the one-hot parser phase type and the field masks
// used to split the CA id / count byte.
// ============================================================================
package oesep_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SidW   = 32;
  localparam int unsigned CaW    = 3;
  localparam int unsigned EidW   = 16;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CntW   = 4;
  localparam int unsigned BcntW  = 2;

  // Masks of the CA id / ensemble-id count byte
  localparam logic [ByteW-1:0] CaMask  = 8'h70;
  localparam logic [ByteW-1:0] CntMask = 8'h0F;

  // Last service id byte index for 16-bit and 32-bit ids
  localparam logic [BcntW-1:0] SidLastShort = 2'd1;
  localparam logic [BcntW-1:0] SidLastLong  = 2'd3;

  // Stream packing widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutUserW = 3;
  localparam int unsigned OutUsedW = SidW + CaW + EidW + IdxW + CntW;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SID  = 5'b00010,
    PH_CAB  = 5'b00100,
    PH_EIDH = 5'b01000,
    PH_EIDL = 5'b10000
  } phase_t;

  // One input byte with its framing flags
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             fig_start;
    logic             fig_end;
    logic             is_other_ensemble;
    logic             is_data_service;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [SidW-1:0] service_id;
    logic [CaW-1:0]  ca_id;
    logic [EidW-1:0] ensemble_id;
    logic [IdxW-1:0] eid_index;
    logic [CntW-1:0] eid_count;
    logic            change_event;
    logic            last_of_entry;
    logic            entry_other_ensemble;
    logic            truncated;
  } result_t;

  // Result of the parse logic for one byte
  typedef struct packed {
    logic    vld;
    result_t res;
  } parse_out_t;

  // Pipeline control shared by the stages
  typedef struct packed {
    logic item_vld;
    logic advance;
  } stage_ctl_t;

endpackage

// ===== sv/oesep_in_stage.sv =====
// ============================================================================
// oesep_in_stage - input register
// Holds one accepted byte until the parse stage consumes it. A new request is
// taken in the same cycle that the held byte moves on.
// ============================================================================
module oesep_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  oesep_pkg::in_item_t  in_item,
  input  logic                 advance,
  output logic                 item_vld,
  output oesep_pkg::in_item_t  item
);

  logic                valid_r;
  logic                valid_nxt;
  oesep_pkg::in_item_t item_r;
  logic                take;

  // Accept when empty or when the held byte leaves this cycle.
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_vld = valid_r;
  assign item     = item_r;

endmodule

// ===== sv/oesep_parse.sv =====
// ============================================================================
// oesep_parse - entry parser state and per-byte decode
// Keeps the parser phase and the fields of the entry being read, and decides
// for each byte whether it produces a result and what that result holds.
// ============================================================================
module oesep_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  oesep_pkg::stage_ctl_t  ctl,
  input  oesep_pkg::in_item_t    item,
  output oesep_pkg::parse_out_t  pout
);

  oesep_pkg::phase_t                 phase_r, phase_nxt;
  logic [oesep_pkg::BcntW-1:0]       bcnt_r, bcnt_nxt;
  logic [oesep_pkg::SidW-1:0]        sid_r, sid_nxt;
  logic [oesep_pkg::CaW-1:0]         ca_r, ca_nxt;
  logic [oesep_pkg::CntW-1:0]        cnt_r, cnt_nxt;
  logic [oesep_pkg::IdxW-1:0]        idx_r, idx_nxt;
  logic [oesep_pkg::ByteW-1:0]       eidh_r, eidh_nxt;
  logic                              oe_r, oe_nxt;
  logic                              pd_r, pd_nxt;

  logic                              start_entry;
  logic                              last_eid;
  logic [oesep_pkg::BcntW-1:0]       sid_last;
  logic [oesep_pkg::ByteW-1:0]       ca_bits;
  logic [oesep_pkg::ByteW-1:0]       cnt_bits;

  // An entry is open once its first service id byte has been taken.
  function automatic logic mid_entry(input oesep_pkg::phase_t ph,
                                     input logic [oesep_pkg::BcntW-1:0] bc);
    logic r;
    r = (ph == oesep_pkg::PH_CAB) || (ph == oesep_pkg::PH_EIDH) ||
        (ph == oesep_pkg::PH_EIDL) || ((ph == oesep_pkg::PH_SID) && (bc != '0));
    return r;
  endfunction

  assign sid_last = pd_r ? oesep_pkg::SidLastLong : oesep_pkg::SidLastShort;
  assign ca_bits  = item.data_byte & oesep_pkg::CaMask;
  assign cnt_bits = item.data_byte & oesep_pkg::CntMask;
  assign last_eid = ({1'b0, idx_r} + 5'd1) >= {1'b0, cnt_r};

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_nxt   = phase_r;
    bcnt_nxt    = bcnt_r;
    sid_nxt     = sid_r;
    ca_nxt      = ca_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    eidh_nxt    = eidh_r;
    oe_nxt      = oe_r;
    pd_nxt      = pd_r;
    start_entry = 1'b0;
    pout        = '0;

    if (item.fig_start) begin
      // A header inside an open entry closes it as truncated.
      if (mid_entry(phase_r, bcnt_r)) begin
        pout.vld                      = 1'b1;
        pout.res.service_id           = sid_r;
        pout.res.ca_id                = ca_r;
        pout.res.eid_index            = idx_r;
        pout.res.eid_count            = cnt_r;
        pout.res.last_of_entry        = 1'b1;
        pout.res.entry_other_ensemble = oe_r;
        pout.res.truncated            = 1'b1;
      end
      oe_nxt      = item.is_other_ensemble;
      pd_nxt      = item.is_data_service;
      start_entry = 1'b1;
    end else begin
      unique case (phase_r)
        oesep_pkg::PH_SID: begin
          sid_nxt = {sid_r[oesep_pkg::SidW-oesep_pkg::ByteW-1:0], item.data_byte};
          if (bcnt_r >= sid_last) begin
            phase_nxt = oesep_pkg::PH_CAB;
            bcnt_nxt  = '0;
          end else begin
            bcnt_nxt = bcnt_r + 2'd1;
          end
        end
        oesep_pkg::PH_CAB: begin
          ca_nxt  = ca_bits[6:4];
          cnt_nxt = cnt_bits[3:0];
          idx_nxt = '0;
          if (cnt_bits[3:0] == '0) begin
            // An entry with no ensemble ids reports a change event.
            pout.vld                      = 1'b1;
            pout.res.service_id           = sid_r;
            pout.res.ca_id                = ca_bits[6:4];
            pout.res.change_event         = 1'b1;
            pout.res.last_of_entry        = 1'b1;
            pout.res.entry_other_ensemble = oe_r;
            start_entry                   = 1'b1;
          end else begin
            phase_nxt = oesep_pkg::PH_EIDH;
          end
        end
        oesep_pkg::PH_EIDH: begin
          eidh_nxt  = item.data_byte;
          phase_nxt = oesep_pkg::PH_EIDL;
        end
        oesep_pkg::PH_EIDL: begin
          pout.vld                      = 1'b1;
          pout.res.service_id           = sid_r;
          pout.res.ca_id                = ca_r;
          pout.res.ensemble_id          = {eidh_r, item.data_byte};
          pout.res.eid_index            = idx_r;
          pout.res.eid_count            = cnt_r;
          pout.res.last_of_entry        = last_eid;
          pout.res.entry_other_ensemble = oe_r;
          if (last_eid) begin
            start_entry = 1'b1;
          end else begin
            idx_nxt   = idx_r + 4'd1;
            phase_nxt = oesep_pkg::PH_EIDH;
          end
        end
        default: begin
          phase_nxt = oesep_pkg::PH_IDLE;
        end
      endcase
    end

    // Clear the entry fields for the next service id.
    if (start_entry) begin
      phase_nxt = oesep_pkg::PH_SID;
      bcnt_nxt  = '0;
      sid_nxt   = '0;
      ca_nxt    = '0;
      cnt_nxt   = '0;
      idx_nxt   = '0;
      eidh_nxt  = '0;
    end

    // The last byte of a FIG closes any open entry as truncated.
    if (item.fig_end) begin
      if (!item.fig_start && mid_entry(phase_nxt, bcnt_nxt)) begin
        if (pout.vld) begin
          pout.res.last_of_entry = 1'b1;
          pout.res.truncated     = 1'b1;
        end else begin
          pout.vld                      = 1'b1;
          pout.res.service_id           = sid_nxt;
          pout.res.ca_id                = ca_nxt;
          pout.res.eid_index            = idx_nxt;
          pout.res.eid_count            = cnt_nxt;
          pout.res.last_of_entry        = 1'b1;
          pout.res.entry_other_ensemble = oe_r;
          pout.res.truncated            = 1'b1;
        end
      end
      phase_nxt = oesep_pkg::PH_IDLE;
    end

    // Nothing happens without a byte moving on.
    if (!ctl.item_vld) begin
      pout.vld = 1'b0;
    end
  end

  // Parser state advances with each consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= oesep_pkg::PH_IDLE;
      bcnt_r  <= '0;
      sid_r   <= '0;
      ca_r    <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      eidh_r  <= '0;
      oe_r    <= 1'b0;
      pd_r    <= 1'b0;
    end else if (ctl.advance) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      sid_r   <= sid_nxt;
      ca_r    <= ca_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      eidh_r  <= eidh_nxt;
      oe_r    <= oe_nxt;
      pd_r    <= pd_nxt;
    end
  end

endmodule

// ===== sv/oesep_out_stage.sv =====
// ============================================================================
// oesep_out_stage - result register
// Holds one result until the downstream side takes it; a new result loads in
// the same cycle that the held one is taken.
// ============================================================================
module oesep_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  oesep_pkg::parse_out_t  pout,
  input  logic                   out_ready,
  output logic                   out_valid,
  output oesep_pkg::result_t     res
);

  logic               valid_r;
  logic               valid_nxt;
  oesep_pkg::result_t res_r;

  // The stage advances only when this register is free or being emptied.
  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = pout.vld;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pout.vld) begin
      res_r <= pout.res;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== sv/oe_service_entry_parser_core.sv =====
// ============================================================================
// oe_service_entry_parser_core - other-ensemble service entry parser
// Parses the data field of FIG 0/24 one byte at a time and emits one request
// per ensemble id, a change event for an entry without ids, and a truncated
// marker when a FIG ends inside an entry.
//
//   channel | direction | tdata                      | tuser / tlast
//   --------+-----------+----------------------------+--------------------------
//   in_     | sink      | data_byte                  | start, OE, P/D / fig_end
//   out_    | source    | sid, ca, eid, index, count | change, OE, trunc / last
//
// One byte is consumed per clock cycle unless the result register is held; a
// byte goes into the input register and its result then into the result register.
// Reset is synchronous, active low, and empties both registers and returns
// the parser to idle.
// With out_tready low the result holds, one more byte waits in the input
// register, and in_tready then drops.
// ============================================================================
module oe_service_entry_parser_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] data_byte
  input  logic [oesep_pkg::InDataW-1:0]        in_tdata,
  // [0] fig_start, [1] is_other_ensemble, [2] is_data_service
  input  logic [oesep_pkg::InUserW-1:0]        in_tuser,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] service_id, [34:32] ca_id, [50:35] ensemble_id,
  // [54:51] eid_index, [58:55] eid_count, [63:59] zero
  output logic [oesep_pkg::OutDataW-1:0]       out_tdata,
  // [0] change_event, [1] entry_other_ensemble, [2] truncated
  output logic [oesep_pkg::OutUserW-1:0]       out_tuser,
  output logic                                 out_tlast
);

  oesep_pkg::in_item_t   in_item;
  oesep_pkg::in_item_t   item;
  oesep_pkg::stage_ctl_t ctl;
  oesep_pkg::parse_out_t pout;
  oesep_pkg::result_t    res;
  logic                  item_vld;

  // Unpack the input request.
  always_comb begin
    in_item.data_byte         = in_tdata;
    in_item.fig_start         = in_tuser[0];
    in_item.is_other_ensemble = in_tuser[1];
    in_item.is_data_service   = in_tuser[2];
    in_item.fig_end           = in_tlast;
  end

  // The held byte moves on when the result register can take its result.
  always_comb begin
    ctl.item_vld = item_vld;
    ctl.advance  = item_vld && (!out_tvalid || out_tready);
  end

  oesep_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (ctl.advance),
    .item_vld (item_vld),
    .item     (item)
  );

  oesep_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (item),
    .pout  (pout)
  );

  oesep_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (ctl.advance),
    .pout      (pout),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .res       (res)
  );

  // Pack the result request.
  assign out_tdata = {{(oesep_pkg::OutDataW - oesep_pkg::OutUsedW){1'b0}},
                      res.eid_count, res.eid_index, res.ensemble_id,
                      res.ca_id, res.service_id};
  assign out_tuser = {res.truncated, res.entry_other_ensemble, res.change_event};
  assign out_tlast = res.last_of_entry;

endmodule

// ===== sv/oesep_checker.sv =====
// ============================================================================
// oesep_checker - port-level checks of the service entry parser
// Watches the top-level ports and checks result framing over time.
// ============================================================================
module oesep_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [oesep_pkg::OutDataW-1:0]  out_tdata,
  input logic [oesep_pkg::OutUserW-1:0]  out_tuser,
  input logic                            out_tlast
);

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A change event closes its entry and carries no ensemble id.
  a_change_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && !out_tuser[2] &&
    out_tdata[58:55] == 4'd0 && out_tdata[50:35] == 16'd0)
    else $error("malformed change event");

  // A truncated result always closes its entry.
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("truncated result not last of entry");

  // A complete ensemble id result has its index inside the count.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[2] |->
    out_tdata[54:51] < out_tdata[58:55])
    else $error("ensemble id index out of range");

endmodule

bind oe_service_entry_parser_core oesep_checker u_oesep_checker (.*);

// ===== tb/oe_service_entry_parser_checker.sv =====
// ============================================================================
// oe_service_entry_parser_checker - result checker for the OE service parser
// Watches both stream channels of the parser. Every accepted input byte is
// run through a local model of the FIG 0/24 entry parser, and the expected
// requests are queued. Every accepted output request is compared field by
// field with the oldest queued one. The mismatch count and the number of
// requests still outstanding are handed to the testbench top.
// ============================================================================
module oe_service_entry_parser_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [oesep_pkg::InDataW-1:0]  in_tdata,
  input  logic [oesep_pkg::InUserW-1:0]  in_tuser,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [oesep_pkg::OutDataW-1:0] out_tdata,
  input  logic [oesep_pkg::OutUserW-1:0] out_tuser,
  input  logic                           out_tlast,
  output int                             mismatch_count,
  output int                             entries_pending
);

  // Local copy of the parser state.
  oesep_pkg::phase_t                ph;
  logic [oesep_pkg::BcntW-1:0]      sid_bytes;
  logic [oesep_pkg::SidW-1:0]       sid_acc;
  logic [oesep_pkg::CaW-1:0]        ca_acc;
  logic [oesep_pkg::CntW-1:0]       cnt_acc;
  logic [oesep_pkg::IdxW-1:0]       idx_acc;
  logic [oesep_pkg::ByteW-1:0]      eid_hi;
  logic                             fig_oe;
  logic                             fig_pd;

  oesep_pkg::result_t entry_results_q[$];
  int                 n_bad = 0;

  // Clear the entry being assembled; the FIG flags are kept.
  task automatic open_entry();
    ph        = oesep_pkg::PH_SID;
    sid_bytes = '0;
    sid_acc   = '0;
    ca_acc    = '0;
    cnt_acc   = '0;
    idx_acc   = '0;
    eid_hi    = '0;
  endtask

  // An entry counts as started once its first service id byte is in.
  function automatic logic in_entry();
    return (ph == oesep_pkg::PH_CAB) || (ph == oesep_pkg::PH_EIDH) ||
           (ph == oesep_pkg::PH_EIDL) ||
           ((ph == oesep_pkg::PH_SID) && (sid_bytes != '0));
  endfunction

  function automatic oesep_pkg::result_t make_result(
    input logic [oesep_pkg::EidW-1:0] eid,
    input logic [oesep_pkg::IdxW-1:0] idx,
    input logic [oesep_pkg::CntW-1:0] cnt,
    input logic chg, input logic fin,
    input logic cut);
    oesep_pkg::result_t r;
    r.service_id           = sid_acc;
    r.ca_id                = ca_acc;
    r.ensemble_id          = eid;
    r.eid_index            = idx;
    r.eid_count            = cnt;
    r.change_event         = chg;
    r.last_of_entry        = fin;
    r.entry_other_ensemble = fig_oe;
    r.truncated            = cut;
    return r;
  endfunction

  // Text form of one request for the mismatch report.
  function automatic string fmt_result(input oesep_pkg::result_t r);
    return $sformatf("sid %h ca %0d eid %h idx %0d cnt %0d chg %b last %b oe %b trunc %b",
                     r.service_id, r.ca_id, r.ensemble_id, r.eid_index, r.eid_count,
                     r.change_event, r.last_of_entry, r.entry_other_ensemble,
                     r.truncated);
  endfunction

  // Advance the model by one FIG byte and queue the request it causes.
  task automatic parse_fig_byte(input oesep_pkg::in_item_t it);
    oesep_pkg::result_t r;
    logic               has;
    logic               fin;
    r   = '0;
    has = 1'b0;
    if (it.fig_start) begin
      // A new header cuts off an unfinished entry of the previous FIG.
      if (in_entry()) begin
        r   = make_result('0, idx_acc, cnt_acc, 1'b0, 1'b1, 1'b1);
        has = 1'b1;
      end
      fig_oe = it.is_other_ensemble;
      fig_pd = it.is_data_service;
      open_entry();
      if (it.fig_end) ph = oesep_pkg::PH_IDLE;
    end else begin
      case (ph)
        oesep_pkg::PH_SID: begin
          sid_acc = {sid_acc[oesep_pkg::SidW-oesep_pkg::ByteW-1:0], it.data_byte};
          if (sid_bytes >= (fig_pd ? oesep_pkg::SidLastLong : oesep_pkg::SidLastShort)) begin
            ph        = oesep_pkg::PH_CAB;
            sid_bytes = '0;
          end else begin
            sid_bytes = sid_bytes + 1'b1;
          end
        end
        oesep_pkg::PH_CAB: begin
          ca_acc  = it.data_byte[6:4];
          cnt_acc = it.data_byte[3:0];
          idx_acc = '0;
          if (cnt_acc == '0) begin
            // No ensemble ids: one change event closes the entry.
            r   = make_result('0, '0, '0, 1'b1, 1'b1, 1'b0);
            has = 1'b1;
            open_entry();
          end else begin
            ph = oesep_pkg::PH_EIDH;
          end
        end
        oesep_pkg::PH_EIDH: begin
          eid_hi = it.data_byte;
          ph     = oesep_pkg::PH_EIDL;
        end
        oesep_pkg::PH_EIDL: begin
          fin = ({1'b0, idx_acc} + 5'd1) >= {1'b0, cnt_acc};
          r   = make_result({eid_hi, it.data_byte}, idx_acc, cnt_acc, 1'b0, fin, 1'b0);
          has = 1'b1;
          if (fin) begin
            open_entry();
          end else begin
            idx_acc = idx_acc + 1'b1;
            ph      = oesep_pkg::PH_EIDH;
          end
        end
        default: begin
          ph = oesep_pkg::PH_IDLE;
        end
      endcase
      // End of FIG inside an entry marks the entry as truncated.
      if (it.fig_end) begin
        if (in_entry()) begin
          if (has) begin
            r.last_of_entry = 1'b1;
            r.truncated     = 1'b1;
          end else begin
            r   = make_result('0, idx_acc, cnt_acc, 1'b0, 1'b1, 1'b1);
            has = 1'b1;
          end
        end
        ph = oesep_pkg::PH_IDLE;
      end
    end
    if (has) entry_results_q = {entry_results_q, r};
  endtask

  // Compare one accepted request with the oldest expected one.
  task automatic check_result();
    oesep_pkg::result_t got;
    oesep_pkg::result_t want;
    got.service_id           = out_tdata[31:0];
    got.ca_id                = out_tdata[34:32];
    got.ensemble_id          = out_tdata[50:35];
    got.eid_index            = out_tdata[54:51];
    got.eid_count            = out_tdata[58:55];
    got.change_event         = out_tuser[0];
    got.entry_other_ensemble = out_tuser[1];
    got.truncated            = out_tuser[2];
    got.last_of_entry        = out_tlast;
    if (entry_results_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("unexpected request: %s", fmt_result(got));
      return;
    end
    want = entry_results_q.pop_front();
    if (got.service_id !== want.service_id || got.ca_id !== want.ca_id ||
        got.ensemble_id !== want.ensemble_id || got.eid_index !== want.eid_index ||
        got.eid_count !== want.eid_count || got.change_event !== want.change_event ||
        got.last_of_entry !== want.last_of_entry ||
        got.entry_other_ensemble !== want.entry_other_ensemble ||
        got.truncated !== want.truncated) begin
      n_bad++;
      if (n_bad <= 10) begin
        $display("mismatch expected: %s", fmt_result(want));
        $display("         actual:   %s", fmt_result(got));
      end
    end
  endtask

  // Outputs are checked before the new byte is predicted, so a request can
  // never be matched against an expectation queued at the same edge.
  always @(posedge clk) begin
    oesep_pkg::in_item_t it;
    if (!rst_n) begin
      open_entry();
      ph     = oesep_pkg::PH_IDLE;
      fig_oe = 1'b0;
      fig_pd = 1'b0;
      entry_results_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        it.data_byte         = in_tdata;
        it.fig_start         = in_tuser[0];
        it.fig_end           = in_tlast;
        it.is_other_ensemble = in_tuser[1];
        it.is_data_service   = in_tuser[2];
        parse_fig_byte(it);
      end
    end
    mismatch_count  <= n_bad;
    entries_pending <= entry_results_q.size();
  end

endmodule

// ===== tb/oe_service_entry_parser_core_tb.sv =====
// ============================================================================
// oe_service_entry_parser_core_tb - testbench of the OE service entry parser
// Drives FIG 0/24 data fields into the parser: a short directed sequence for
// the edge cases (stray bytes, empty FIG, change events, truncated entries),
// then random FIGs, mostly well formed with random content, mixed with cut
// FIGs and stray bytes. Both channels stall at random; the output is held off
// once for a long stretch. A separate checker predicts and compares.
// ============================================================================
module oe_service_entry_parser_core_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int          RandomBytes = 850;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [oesep_pkg::InDataW-1:0]  in_tdata = '0;
  logic [oesep_pkg::InUserW-1:0]  in_tuser = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [oesep_pkg::OutDataW-1:0] out_tdata;
  logic [oesep_pkg::OutUserW-1:0] out_tuser;
  logic                           out_tlast;

  int          mismatch_count;
  int          entries_pending;
  int unsigned cycle_cnt = 0;
  int          hold_left = 0;
  int          fig_bytes_sent = 0;
  logic        in_gaps_on = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  oe_service_entry_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  oe_service_entry_parser_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .entries_pending (entries_pending)
  );

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output side: one long hold-off, a window without stalls, random otherwise.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (cycle_cnt == 500) begin
      out_tready <= 1'b0;
      hold_left  <= 250;
    end else if (cycle_cnt >= 800 && cycle_cnt < 1000) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 26);
    end
  end

  // Offer one byte, with optional idle cycles first, until it is accepted.
  task automatic offer_fig_byte(input logic [7:0] b, input logic st, input logic en,
                                input logic oe, input logic pd);
    while (in_gaps_on && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= {pd, oe, st};
    in_tlast  <= en;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the input idle until every expected request has come out.
  task automatic wait_entries_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (entries_pending != 0);
  endtask

  // Send one FIG with random entries; a broken FIG is cut at a random byte
  // and ends there or simply runs into the next header.
  task automatic send_fig(input logic oe, input logic pd, input int n_ent,
                          input logic broken);
    logic [7:0] body[$];
    logic [7:0] b;
    int         cnt;
    int         keep;
    logic       ends;
    body = {};
    repeat (n_ent) begin
      repeat (pd ? 4 : 2) body = {body, 8'($urandom)};
      cnt = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
      b = 8'($urandom);
      b[3:0] = 4'(cnt);
      body = {body, b};
      repeat (2 * cnt) body = {body, 8'($urandom)};
    end
    keep = broken ? $urandom_range(body.size() - 1) : body.size();
    ends = broken ? logic'($urandom_range(1)) : 1'b1;
    offer_fig_byte(8'($urandom), 1'b1, ends && (keep == 0), oe, pd);
    fig_bytes_sent++;
    for (int i = 0; i < keep; i++) begin
      in_gaps_on = !(fig_bytes_sent >= 200 && fig_bytes_sent < 350);
      offer_fig_byte(body[i], 1'b0, ends && (i == keep - 1),
                     logic'($urandom_range(1)), logic'($urandom_range(1)));
      fig_bytes_sent++;
    end
  endtask

  initial begin
    logic paused;
    int   pick;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Stray byte outside a FIG, then an empty FIG.
    offer_fig_byte(8'hA5, 1'b0, 1'b1, 1'b1, 1'b1);
    offer_fig_byte(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
    // Short ids: a change event with all-ones fields, then one all-ones id.
    offer_fig_byte(8'h00, 1'b1, 1'b0, 1'b1, 1'b0);
    offer_fig_byte(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'hF0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h01, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
    // Long id, count 15, FIG ends right after the second ensemble id.
    offer_fig_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b1);
    offer_fig_byte(8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h01, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h02, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h03, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h8F, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h12, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h34, 1'b0, 1'b1, 1'b0, 1'b0);
    // A new header cuts a service id short; that header is also its end.
    offer_fig_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
    offer_fig_byte(8'h55, 1'b0, 1'b0, 1'b1, 1'b1);
    offer_fig_byte(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_entries_drained();

    // Random FIGs: mostly well formed, some cut, a few stray bytes.
    while (fig_bytes_sent < RandomBytes) begin
      if (!paused && fig_bytes_sent >= 450) begin
        wait_entries_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        offer_fig_byte(8'($urandom), 1'b0, logic'($urandom_range(1)),
                       logic'($urandom_range(1)), logic'($urandom_range(1)));
      end else begin
        send_fig(logic'($urandom_range(1)), logic'($urandom_range(1)),
                 $urandom_range(1, 4), pick < 24);
      end
    end

    // Drain, then let the last updates settle before reporting.
    wait_entries_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && entries_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/oesep_pkg.sv
sv/oesep_in_stage.sv
sv/oesep_parse.sv
sv/oesep_out_stage.sv
sv/oe_service_entry_parser_core.sv
sv/oesep_checker.sv
tb/oe_service_entry_parser_checker.sv
tb/oe_service_entry_parser_core_tb.sv
